### src/frf_pkg.sv
// Package for the ring-buffer FIR filter.
// Holds the command codes, the back-end state type and fixed field widths.
// No dependencies.
`default_nettype none

package frf_pkg;

  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TAPS_W = 5;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } st_e;

endpackage

`default_nettype wire

### src/frf_in_if.sv
// Input request channel of the FIR filter: valid/ready plus one request.
// Depends on frf_pkg for the slot width.
`default_nettype none

interface frf_in_if #(
  parameter int unsigned SW = 16,
  parameter int unsigned CW = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [SW-1:0]        sample_in;
  logic [frf_pkg::SLOT_W-1:0]  coef_slot;
  logic signed [CW-1:0]        coef_value;

  modport source (output valid, command, sample_in, coef_slot, coef_value, input ready);
  modport sink   (input valid, command, sample_in, coef_slot, coef_value, output ready);
endinterface

`default_nettype wire

### src/frf_cmd_if.sv
// Classified request channel between the FIR front end and back end.
// Depends on frf_pkg for the command type and slot width.
`default_nettype none

interface frf_cmd_if #(
  parameter int unsigned SW = 16,
  parameter int unsigned CW = 16
);
  logic                        valid;
  logic                        ready;
  frf_pkg::cmd_e               op;
  logic signed [SW-1:0]        sample;
  logic [frf_pkg::SLOT_W-1:0]  slot;
  logic signed [CW-1:0]        value;

  modport source (output valid, op, sample, slot, value, input ready);
  modport sink   (input valid, op, sample, slot, value, output ready);
endinterface

`default_nettype wire

### src/frf_out_if.sv
// Result channel of the FIR filter: valid/ready plus filtered value and flag.
// No dependencies.
`default_nettype none

interface frf_out_if #(
  parameter int unsigned SW = 16
);
  logic                  valid;
  logic                  ready;
  logic signed [SW-1:0]  filtered;
  logic                  saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

`default_nettype wire

### src/frf_cfg_if.sv
// Configuration write channel of the FIR filter (tap count register).
// Depends on frf_pkg for the register width.
`default_nettype none

interface frf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [frf_pkg::TAPS_W-1:0]  taps_in_use;

  modport source (output valid, taps_in_use, input ready);
  modport sink   (input valid, taps_in_use, output ready);
endinterface

`default_nettype wire

### src/frf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module frf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

`default_nettype wire

### src/frf_front.sv
// FIR front end: accepts requests, drops unused codes, queues the rest.
// Depends on frf_pkg, frf_in_if and frf_cmd_if.
`default_nettype none

module frf_front #(
  parameter int unsigned SW = 16,
  parameter int unsigned CW = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frf_in_if.sink    in_ch,
  frf_cmd_if.source cmd_ch
);
  typedef struct packed {
    frf_pkg::cmd_e               op;
    logic signed [SW-1:0]        sample;
    logic [frf_pkg::SLOT_W-1:0]  slot;
    logic signed [CW-1:0]        value;
  } entry_t;

  entry_t     fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  logic       push;
  logic       pop;
  entry_t     wr_entry;

  always_comb begin
    unique case (in_ch.command)
      frf_pkg::CMD_SAMPLE,
      frf_pkg::CMD_COEF,
      frf_pkg::CMD_CLEAR: keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign pop         = cmd_ch.valid && cmd_ch.ready;

  assign wr_entry.op     = frf_pkg::cmd_e'(in_ch.command);
  assign wr_entry.sample = in_ch.sample_in;
  assign wr_entry.slot   = in_ch.coef_slot;
  assign wr_entry.value  = in_ch.coef_value;

  assign cmd_ch.valid  = (cnt_q != 2'd0);
  assign cmd_ch.op     = fifo_q[rd_ptr_q].op;
  assign cmd_ch.sample = fifo_q[rd_ptr_q].sample;
  assign cmd_ch.slot   = fifo_q[rd_ptr_q].slot;
  assign cmd_ch.value  = fifo_q[rd_ptr_q].value;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= wr_entry;
    end
  end
endmodule

`default_nettype wire

### src/frf_back.sv
// FIR back end: coefficient loads, history clear and the tap-serial MAC.
// Depends on frf_pkg, frf_ram, frf_cmd_if, frf_out_if and frf_cfg_if.
`default_nettype none

module frf_back #(
  parameter int unsigned MAX_TAPS = 16,
  parameter int unsigned SW       = 16,
  parameter int unsigned CW       = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frf_cmd_if.sink   cmd_ch,
  frf_cfg_if.sink   cfg_ch,
  frf_out_if.source out_ch
);
  localparam int unsigned TW      = frf_pkg::TAPS_W;
  localparam int unsigned IW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned XW      = (IW > TW) ? IW : TW;
  localparam int unsigned TAP_CAP = (MAX_TAPS < 31) ? MAX_TAPS : 31;
  localparam int unsigned PW      = SW + CW;
  localparam int unsigned AW      = (PW + 5 < 64) ? PW + 5 : 64;

  frf_pkg::st_e state_q, state_d;

  logic [TW-1:0]       taps_q;
  logic [TW-1:0]       taps_act;
  logic [IW-1:0]       last_act;
  logic [IW-1:0]       wp_q;
  logic [IW-1:0]       wp_eff;
  logic [IW-1:0]       last_q;
  logic [IW-1:0]       i_q;
  logic [IW-1:0]       idx_q;
  logic [MAX_TAPS-1:0] hvalid_q;
  logic [MAX_TAPS-1:0] cvalid_q;

  logic cmd_ready;
  logic start;
  logic coef_we;
  logic clear;
  logic issue;
  logic finish;

  logic v1_q, l1_q, hv1_q, cv1_q;
  logic v2_q, l2_q;
  logic fin_q;

  logic        [SW-1:0] hist_rd;
  logic        [CW-1:0] coef_rd;
  logic signed [SW-1:0] h_m;
  logic signed [CW-1:0] c_m;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] prod_x;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] acc_d;
  logic                 ovf;

  logic [AW-PW+1:0]     top;
  logic                 sat;
  logic signed [SW-1:0] y;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_data_q;
  logic                 out_sat_q;
  logic                 out_take;

  // active tap count: zero counts as one, clamp at the ring size
  always_comb begin
    taps_act = taps_q;
    if (taps_q == '0) begin
      taps_act = TW'(1);
    end
    if (taps_act > TW'(TAP_CAP)) begin
      taps_act = TW'(TAP_CAP);
    end
  end

  assign last_act = IW'(taps_act - TW'(1));
  assign wp_eff   = (XW'(wp_q) >= XW'(taps_act)) ? '0 : wp_q;
  assign out_take = out_valid_q && out_ch.ready;

  always_comb begin
    state_d   = state_q;
    cmd_ready = 1'b0;
    start     = 1'b0;
    coef_we   = 1'b0;
    clear     = 1'b0;
    issue     = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      frf_pkg::ST_IDLE: begin
        if (cmd_ch.valid) begin
          unique case (cmd_ch.op)
            frf_pkg::CMD_SAMPLE: begin
              if (!out_valid_q || out_ch.ready) begin
                cmd_ready = 1'b1;
                start     = 1'b1;
                state_d   = frf_pkg::ST_RUN;
              end
            end
            frf_pkg::CMD_COEF: begin
              cmd_ready = 1'b1;
              coef_we   = (int'(cmd_ch.slot) < MAX_TAPS);
            end
            frf_pkg::CMD_CLEAR: begin
              cmd_ready = 1'b1;
              clear     = 1'b1;
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      frf_pkg::ST_RUN: begin
        issue = 1'b1;
        if (i_q == last_q) begin
          state_d = frf_pkg::ST_WAIT;
        end
      end
      frf_pkg::ST_WAIT: begin
        if (fin_q) begin
          finish  = 1'b1;
          state_d = frf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frf_pkg::ST_IDLE;
      end
    endcase
  end

  assign cmd_ch.ready = cmd_ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  frf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (start),
    .waddr_i (wp_eff),
    .wdata_i (cmd_ch.sample),
    .raddr_i (idx_q),
    .rdata_o (hist_rd)
  );

  frf_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (IW'(cmd_ch.slot)),
    .wdata_i (cmd_ch.value),
    .raddr_i (i_q),
    .rdata_o (coef_rd)
  );

  // unwritten entries read as zero
  assign h_m = hv1_q ? signed'(hist_rd) : '0;
  assign c_m = cv1_q ? signed'(coef_rd) : '0;

  always_comb begin
    prod_x = AW'(prod_q);
    sum    = acc_q + prod_x;
    ovf    = (acc_q[AW-1] == prod_x[AW-1]) && (sum[AW-1] != acc_q[AW-1]);
    acc_d  = sum;
    if (ovf) begin
      acc_d = prod_x[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end
  end

  // shift down by CW-1 and clamp to SW bits
  always_comb begin
    top = acc_q[AW-1:SW+CW-2];
    sat = !((&top) || !(|top));
    y   = acc_q[SW+CW-2:CW-1];
    if (sat) begin
      y = acc_q[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q      <= frf_pkg::TAPS_RESET;
      wp_q        <= '0;
      hvalid_q    <= '0;
      cvalid_q    <= '0;
      v1_q        <= 1'b0;
      l1_q        <= 1'b0;
      v2_q        <= 1'b0;
      l2_q        <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        taps_q <= cfg_ch.taps_in_use;
      end
      if (clear) begin
        hvalid_q <= '0;
        wp_q     <= '0;
      end else if (start) begin
        hvalid_q[wp_eff] <= 1'b1;
        wp_q             <= (wp_eff == last_act) ? '0 : wp_eff + IW'(1);
      end
      if (coef_we) begin
        cvalid_q[IW'(cmd_ch.slot)] <= 1'b1;
      end
      v1_q  <= issue;
      l1_q  <= issue && (i_q == last_q);
      v2_q  <= v1_q;
      l2_q  <= l1_q;
      fin_q <= v2_q && l2_q;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      last_q <= last_act;
      i_q    <= '0;
      idx_q  <= wp_eff;
      acc_q  <= '0;
    end else begin
      if (issue) begin
        i_q   <= i_q + IW'(1);
        idx_q <= (idx_q == '0) ? last_q : idx_q - IW'(1);
      end
      if (v2_q) begin
        acc_q <= acc_d;
      end
    end
    hv1_q  <= hvalid_q[idx_q];
    cv1_q  <= cvalid_q[i_q];
    prod_q <= h_m * c_m;
    if (finish) begin
      out_data_q <= y;
      out_sat_q  <= sat;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.filtered  = out_data_q;
  assign out_ch.saturated = out_sat_q;
endmodule

`default_nettype wire

### src/fir_filter_ring_buffer.sv
// Top level of the ring-buffer FIR filter: front end, request queue, MAC back end.
// Depends on frf_pkg, the channel interfaces, frf_front and frf_back.
//
// Channels: in_ch takes requests (command 0 sample, 1 coefficient load,
// 2 history clear; command 3 is dropped). out_ch gives one result per sample
// request: the sum shifted down to Q1.15 and clamped, plus a saturation flag.
// cfg_ch writes the tap count; it is always ready. Write it only while idle; the block does not enforce this.
// A two-entry queue separates request intake from the MAC back end, so
// loads and clears are absorbed while a sample is being filtered.
// A sample is filtered by the single shared multiply-accumulate unit, which
// walks one tap per cycle over the history RAM for T taps, T being the active
// tap count (1 to MAX_TAPS); the back end takes no new request until the
// current sample's result is registered. Coefficient loads and clears are
// handled while the back end is idle and do not leave the idle state.
// Reset clears history and coefficients through per-entry valid bits, zeroes
// the write position and sets the tap count to 16; there is no clearing pass.
// A stalled receiver holds the result register; the back end then holds the
// next sample request until the result is taken, and the queue fills.
`default_nettype none

module fir_filter_ring_buffer #(
  parameter int unsigned MAX_TAPS     = 16,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frf_in_if.sink    in_ch,
  frf_cfg_if.sink   cfg_ch,
  frf_out_if.source out_ch
);
  frf_cmd_if #(.SW(SAMPLE_WIDTH), .CW(COEF_WIDTH)) cmd_ch ();

  frf_front #(
    .SW (SAMPLE_WIDTH),
    .CW (COEF_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cmd_ch (cmd_ch)
  );

  frf_back #(
    .MAX_TAPS (MAX_TAPS),
    .SW       (SAMPLE_WIDTH),
    .CW       (COEF_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_ch (cmd_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  a_sample_frees_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_ch.valid && cmd_ch.ready && cmd_ch.op == frf_pkg::CMD_SAMPLE) |=> !out_ch.valid)
    else $error("sample started while a result was still pending");

  a_full_queue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> cmd_ch.valid)
    else $error("front end stalls with an empty queue");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(!cmd_ch.ready))
    else $error("result appeared without the back end being busy");
endmodule

`default_nettype wire

### dv/fir_filter_ring_buffer_tb.sv
// Testbench for fir_filter_ring_buffer: directed and random requests with a
// scoreboard that tracks history, coefficients and write position itself.
// Depends on frf_pkg, the frf_*_if channel interfaces and the filter RTL.
`timescale 1ns / 1ps

module fir_filter_ring_buffer_tb;

  localparam int unsigned MAX_TAPS   = 16;
  localparam int unsigned SW         = 16;
  localparam int unsigned CW         = 16;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          SETTLE     = 40;
  localparam int          QUIET_MAX  = 3000;
  localparam int          REQ_TOTAL  = 600;

  typedef struct {
    logic signed [SW-1:0] filtered;
    logic                 saturated;
  } fir_y_t;

  class fir_score;
    logic signed [SW-1:0]       hist [MAX_TAPS];
    logic signed [CW-1:0]       coef [MAX_TAPS];
    int unsigned                wpos;
    logic [frf_pkg::TAPS_W-1:0] taps;
    fir_y_t                     y_pending[$];
    int                         mismatches;

    function new();
      foreach (hist[i]) begin
        hist[i] = '0;
        coef[i] = '0;
      end
      wpos       = 0;
      taps       = frf_pkg::TAPS_RESET;
      mismatches = 0;
    endfunction

    function void set_taps(logic [frf_pkg::TAPS_W-1:0] t);
      taps = t;
    endfunction

    function fir_y_t mac_window(logic signed [SW-1:0] smp);
      int unsigned n;
      int unsigned idx;
      int unsigned i;
      longint      acc;
      longint      y;
      fir_y_t      r;
      n = (taps == 0) ? 1 : ((taps > MAX_TAPS) ? MAX_TAPS : taps);
      if (wpos >= n) wpos = 0;
      hist[wpos] = smp;
      idx = wpos;
      acc = 0;
      for (i = 0; i < n; i++) begin
        acc += longint'(coef[i]) * longint'(hist[idx]);
        idx = (idx == 0) ? n - 1 : idx - 1;
      end
      wpos = (wpos + 1) % n;
      y = acc >>> (CW - 1);
      r.saturated = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.saturated = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.saturated = 1'b1;
      end
      r.filtered = y[SW-1:0];
      return r;
    endfunction

    function void note_request(logic [1:0] cmd, logic signed [SW-1:0] smp,
                               logic [frf_pkg::SLOT_W-1:0] slot,
                               logic signed [CW-1:0] val);
      case (cmd)
        frf_pkg::CMD_SAMPLE: y_pending.push_back(mac_window(smp));
        frf_pkg::CMD_COEF:   coef[slot] = val;
        frf_pkg::CMD_CLEAR: begin
          foreach (hist[i]) hist[i] = '0;
          wpos = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [SW-1:0] got_y, logic got_sat);
      fir_y_t e;
      if (y_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: filtered %0d saturated %0b",
                   $realtime, got_y, got_sat);
        return;
      end
      e = y_pending.pop_front();
      if (got_y !== e.filtered || got_sat !== e.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: filtered exp %0d got %0d, saturated exp %0b got %0b",
                   $realtime, e.filtered, got_y, e.saturated, got_sat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  frf_in_if  #(.SW(SW), .CW(CW)) in_ch ();
  frf_cfg_if                     cfg_ch ();
  frf_out_if #(.SW(SW))          out_ch ();

  fir_filter_ring_buffer #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_WIDTH(SW),
    .COEF_WIDTH  (CW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  fir_score board = new();
  int       stall_pct = 0;
  int       quiet_cycles = 0;
  int       sent = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) board.set_taps(cfg_ch.taps_in_use);
      if (in_ch.valid && in_ch.ready)
        board.note_request(in_ch.command, in_ch.sample_in, in_ch.coef_slot,
                           in_ch.coef_value);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.filtered, out_ch.saturated);
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts.
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic signed [15:0] rand16();
    case ($urandom_range(0, 24))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic [1:0] cmd, input logic signed [SW-1:0] smp,
                          input logic [frf_pkg::SLOT_W-1:0] slot,
                          input logic signed [CW-1:0] val);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.sample_in  <= smp;
    in_ch.coef_slot  <= slot;
    in_ch.coef_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Hold off until every pending result is back and the back end is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.y_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_taps(input logic [frf_pkg::TAPS_W-1:0] t);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.taps_in_use <= t;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random();
    int          r;
    logic [1:0]  cmd;
    r = $urandom_range(0, 99);
    if (r < 68)      cmd = frf_pkg::CMD_SAMPLE;
    else if (r < 86) cmd = frf_pkg::CMD_COEF;
    else if (r < 92) cmd = frf_pkg::CMD_CLEAR;
    else             cmd = CMD_UNUSED;
    send_req(cmd, rand16(), 4'($urandom_range(0, 15)), rand16());
  endtask

  initial begin
    int                         n;
    int                         r;
    logic [frf_pkg::TAPS_W-1:0] t;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= frf_pkg::CMD_SAMPLE;
    in_ch.sample_in    <= '0;
    in_ch.coef_slot    <= '0;
    in_ch.coef_value   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.taps_in_use <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, saturation both ways, unused command, tap limits.
    write_taps(5'd16);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_COEF, 16'sh0000, 4'd0, 16'sh8000);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh8000, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_COEF, 16'sh0000, 4'd1, 16'sh8000);
    send_req(frf_pkg::CMD_COEF, 16'sh0000, 4'd15, 16'sh7FFF);
    send_req(frf_pkg::CMD_CLEAR, 16'sh0000, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sh0000);
    send_req(CMD_UNUSED, 16'shFFFF, 4'd15, 16'shFFFF);
    send_req(frf_pkg::CMD_SAMPLE, 16'shFFFF, 4'd15, 16'sh7FFF);
    drain();
    write_taps(5'd1);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh8000, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh3039, 4'd0, 16'sh0000);
    drain();
    write_taps(5'd0);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sh0000);
    drain();
    write_taps(5'd31);
    send_req(frf_pkg::CMD_CLEAR, 16'sh0000, 4'd0, 16'sh0000);
    repeat (6) send_req(frf_pkg::CMD_SAMPLE, rand16(), 4'd0, 16'sh0000);
    drain();
    // Shrink taps without a clear so the write position falls outside.
    write_taps(5'd3);
    send_req(frf_pkg::CMD_SAMPLE, 16'sh1234, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_SAMPLE, 16'shEDCB, 4'd0, 16'sh0000);
    send_req(frf_pkg::CMD_CLEAR, 16'sh0000, 4'd0, 16'sh0000);
    drain();

    sent = 0;
    while (sent < REQ_TOTAL) begin
      r = $urandom_range(0, 99);
      if (r < 10)      t = 5'd0;
      else if (r < 20) t = 5'($urandom_range(17, 31));
      else if (r < 28) t = 5'd1;
      else if (r < 40) t = 5'd16;
      else             t = 5'($urandom_range(2, 15));
      if (sent >= REQ_TOTAL - 100) stall_pct = 0;
      else stall_pct = $urandom_range(0, 2) * 15;
      write_taps(t);
      if ($urandom_range(0, 99) < 85)
        send_req(frf_pkg::CMD_CLEAR, rand16(), 4'($urandom_range(0, 15)), rand16());
      n = $urandom_range(40, 80);
      repeat (n) send_random();
      drain();
    end

    if (board.mismatches == 0 && board.y_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
